// File: hw/rtl/gsa_pkg.sv
package gsa_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int GEN_BITS   = 32;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int OP_W       = 3;
  localparam int IDX_W      = 8;
  localparam int HGEN_W     = 32;
  localparam int STAT_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_RESOLVE = 3'd1,
    OP_DETACH = 3'd2,
    OP_KILL   = 3'd3,
    OP_FREE   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    logic [GEN_BITS-1:0] gen;
    logic                occupied;
    logic                finished;
  } slot_entry_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] addr;
    slot_entry_t        data;
  } slot_wr_t;

  localparam slot_entry_t SLOT_RESET = '{gen: GEN_BITS'(1), occupied: 1'b0, finished: 1'b0};

  // next generation, wrapping within GEN_BITS and never 0
  function automatic logic [GEN_BITS-1:0] bump_gen(input logic [GEN_BITS-1:0] g);
    logic [GEN_BITS-1:0] n;
    n = g + GEN_BITS'(1);
    return (n == '0) ? GEN_BITS'(1) : n;
  endfunction

endpackage

// File: hw/rtl/generational_slot_allocator.sv
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------------
// in       | in_valid / in_stall    | in_operation, in_slot_index, in_handle_generation
// out      | out_valid / out_stall  | out_status, out_index, out_generation,
//          |                        | out_active_count
//
// an item is read, then resolved: the accept edge issues the slot memory read (and the
// free stack read for allocate), then S_EXEC resolves and writes back
// allocate from the free stack goes stack read, then slot read, then write back in S_ALLOC
// clear sweeps one slot a cycle through the slot memory port; only slots ever
// handed out are visited
// reset clears control state and the slot valid bits at once, no clearing pass
// a stalled output holds the item in its final cycle; in_stall is high whenever busy
module generational_slot_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gsa_pkg::OP_W-1:0]    in_operation,
  input  logic [gsa_pkg::IDX_W-1:0]   in_slot_index,
  input  logic [gsa_pkg::HGEN_W-1:0]  in_handle_generation,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gsa_pkg::STAT_W-1:0]  out_status,
  output logic [gsa_pkg::IDX_W-1:0]   out_index,
  output logic [gsa_pkg::HGEN_W-1:0]  out_generation,
  output logic [gsa_pkg::CNT_W-1:0]   out_active_count
);
  import gsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_ALLOC = 4'b0100,
    S_CLR   = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  op_t                op_r;
  logic [IDX_W-1:0]   idx_r;
  logic [HGEN_W-1:0]  hgen_r;
  logic [CNT_W-1:0]   depth_r, depth_nxt;   // free stack fill
  logic [CNT_W-1:0]   fresh_r, fresh_nxt;   // next never-used index
  logic [CNT_W-1:0]   live_r, live_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;       // clear sweep position

  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  status_t            out_status_r, stat_nxt;
  logic [IDX_W-1:0]   out_index_r, oidx_nxt;
  logic [HGEN_W-1:0]  out_gen_r, ogen_nxt;
  logic [CNT_W-1:0]   out_live_r;

  logic               accept;
  logic               go;

  // slot store
  logic               slot_rd_en;
  logic [SLOT_AW-1:0] slot_raddr;
  slot_wr_t           slot_wr;
  slot_entry_t        entry;
  logic [SLOT_AW-1:0] entry_addr;

  // free stack
  logic               stk_re;
  logic [SLOT_AW-1:0] stk_raddr;
  logic               stk_we;
  logic [SLOT_AW-1:0] stk_waddr;
  logic [SLOT_AW-1:0] stk_q;

  // handle check
  logic               in_range;
  status_t            chk_status;

  gsa_slot_store u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (slot_rd_en),
    .rd_addr  (slot_raddr),
    .wr       (slot_wr),
    .rd_entry (entry),
    .rd_addr_q(entry_addr)
  );

  gsa_ram #(
    .WIDTH(SLOT_AW),
    .DEPTH(SLOT_COUNT)
  ) u_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(entry_addr),
    .re   (stk_re),
    .raddr(stk_raddr),
    .rdata(stk_q)
  );

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign go       = !out_valid_r || !out_stall;

  // index must have been handed out at some point since the last clear
  assign in_range = (CNT_W'(idx_r) < fresh_r) && (CNT_W'(idx_r) < CNT_W'(SLOT_COUNT));

  always_comb begin
    priority if (hgen_r == '0 || !in_range) begin
      chk_status = ST_INVALID;
    end else if (HGEN_W'(entry.gen) != hgen_r) begin
      chk_status = ST_INVALID;
    end else if (!entry.occupied) begin
      chk_status = ST_EMPTY;
    end else begin
      chk_status = ST_OK;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    fresh_nxt     = fresh_r;
    live_nxt      = live_r;
    cnt_nxt       = cnt_r;
    out_load      = 1'b0;
    stat_nxt      = ST_OK;
    oidx_nxt      = idx_r;
    ogen_nxt      = '0;
    slot_rd_en    = 1'b0;
    slot_raddr    = SLOT_AW'(in_slot_index);
    slot_wr.en    = 1'b0;
    slot_wr.addr  = entry_addr;
    slot_wr.data  = '{gen: bump_gen(entry.gen), occupied: 1'b0, finished: 1'b0};
    stk_re        = 1'b0;
    stk_raddr     = SLOT_AW'(depth_r - CNT_W'(1));
    stk_we        = 1'b0;
    stk_waddr     = SLOT_AW'(depth_r);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          slot_rd_en = 1'b1;
          // allocate looks at the next fresh slot; a stack pop rereads later
          if (in_operation == OP_ALLOC) begin
            slot_raddr = SLOT_AW'(fresh_r);
            stk_re     = 1'b1;
          end
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (op_r)
          OP_ALLOC: begin
            if (depth_r != '0) begin
              // pop: fetch the slot named by the top of the stack
              slot_rd_en = 1'b1;
              slot_raddr = stk_q;
              depth_nxt  = depth_r - CNT_W'(1);
              state_nxt  = S_ALLOC;
            end else if (go) begin
              out_load  = 1'b1;
              state_nxt = S_IDLE;
              if (fresh_r < CNT_W'(SLOT_COUNT)) begin
                fresh_nxt    = fresh_r + CNT_W'(1);
                slot_wr.en   = 1'b1;
                slot_wr.data = '{gen: entry.gen, occupied: 1'b1, finished: 1'b0};
                live_nxt     = live_r + CNT_W'(1);
                oidx_nxt     = IDX_W'(entry_addr);
                ogen_nxt     = HGEN_W'(entry.gen);
              end else begin
                stat_nxt = ST_FULL;
              end
            end
          end

          OP_RESOLVE: begin
            if (go) begin
              out_load  = 1'b1;
              state_nxt = S_IDLE;
              stat_nxt  = (chk_status == ST_OK && entry.finished) ? ST_EMPTY : chk_status;
            end
          end

          OP_DETACH, OP_FREE: begin
            if (go) begin
              out_load  = 1'b1;
              state_nxt = S_IDLE;
              // free by index skips the generation check
              if (op_r == OP_FREE) begin
                if (!in_range) begin
                  stat_nxt = ST_INVALID;
                end else if (!entry.occupied) begin
                  stat_nxt = ST_EMPTY;
                end else begin
                  stat_nxt = ST_OK;
                end
              end else begin
                stat_nxt = chk_status;
              end
              if (stat_nxt == ST_OK) begin
                slot_wr.en = 1'b1;
                if (!entry.finished && live_r != '0) begin
                  live_nxt = live_r - CNT_W'(1);
                end
                if (depth_r < CNT_W'(SLOT_COUNT)) begin
                  stk_we    = 1'b1;
                  depth_nxt = depth_r + CNT_W'(1);
                end
              end
            end
          end

          OP_KILL: begin
            if (go) begin
              out_load  = 1'b1;
              state_nxt = S_IDLE;
              stat_nxt  = chk_status;
              if (chk_status == ST_OK) begin
                if (entry.finished) begin
                  stat_nxt = ST_EMPTY;
                end else begin
                  slot_wr.en   = 1'b1;
                  slot_wr.data = '{gen: entry.gen, occupied: 1'b1, finished: 1'b1};
                  if (live_r != '0) begin
                    live_nxt = live_r - CNT_W'(1);
                  end
                end
              end
            end
          end

          OP_CLEAR: begin
            cnt_nxt   = '0;
            state_nxt = S_CLR;
          end

          default: begin
            if (go) begin
              out_load  = 1'b1;
              state_nxt = S_IDLE;
              stat_nxt  = ST_INVALID;
            end
          end
        endcase
      end

      S_ALLOC: begin
        if (go) begin
          out_load     = 1'b1;
          state_nxt    = S_IDLE;
          slot_wr.en   = 1'b1;
          slot_wr.data = '{gen: entry.gen, occupied: 1'b1, finished: 1'b0};
          live_nxt     = live_r + CNT_W'(1);
          oidx_nxt     = IDX_W'(entry_addr);
          ogen_nxt     = HGEN_W'(entry.gen);
        end
      end

      S_CLR: begin
        // read slot cnt while writing back slot cnt-1
        if (cnt_r != '0 && (cnt_r != fresh_r || go) && entry.occupied) begin
          slot_wr.en = 1'b1;
        end
        if (cnt_r < fresh_r) begin
          slot_rd_en = 1'b1;
          slot_raddr = SLOT_AW'(cnt_r);
          cnt_nxt    = cnt_r + CNT_W'(1);
        end else if (go) begin
          depth_nxt = '0;
          fresh_nxt = '0;
          live_nxt  = '0;
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      fresh_r     <= '0;
      live_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      fresh_r     <= fresh_nxt;
      live_r      <= live_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item fields and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_operation);
      idx_r  <= in_slot_index;
      hgen_r <= in_handle_generation;
    end
    if (out_load) begin
      out_status_r <= stat_nxt;
      out_index_r  <= oidx_nxt;
      out_gen_r    <= ogen_nxt;
      out_live_r   <= live_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_index        = out_index_r;
  assign out_generation   = out_gen_r;
  assign out_active_count = out_live_r;

endmodule

// File: hw/rtl/gsa_ram.sv
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/gsa_slot_store.sv
module gsa_slot_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [gsa_pkg::SLOT_AW-1:0]   rd_addr,
  input  gsa_pkg::slot_wr_t             wr,
  output gsa_pkg::slot_entry_t          rd_entry,
  output logic [gsa_pkg::SLOT_AW-1:0]   rd_addr_q
);
  import gsa_pkg::*;

  logic [SLOT_COUNT-1:0]     valid_r;
  logic [SLOT_AW-1:0]        rd_addr_r;
  logic [$bits(slot_entry_t)-1:0] ram_q;

  gsa_ram #(
    .WIDTH($bits(slot_entry_t)),
    .DEPTH(SLOT_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (wr.en),
    .waddr(wr.addr),
    .wdata(wr.data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  // entries never written read as the reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_r <= rd_addr;
    end
  end

  assign rd_entry  = valid_r[rd_addr_r] ? slot_entry_t'(ram_q) : SLOT_RESET;
  assign rd_addr_q = rd_addr_r;

endmodule
